[rtl/decimal_digit_display_framer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Decimal digit display framer - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_DIGIT_DISPLAY_FRAMER_UNIT_DEFINES_SVH
`define DECIMAL_DIGIT_DISPLAY_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DDF_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define DDF_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/ddf_pkg.sv]
// ----------------------------------------------------------------------------
// ddf_pkg
// Types and constants shared by the decimal digit display framer modules.
// ----------------------------------------------------------------------------
package ddf_pkg;

    localparam int unsigned VALUE_W = 31;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned CODE_W  = 4;

    localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;

    // Reciprocal of ten for 32-bit dividends: q = (x * RECIP10) >> RECIP10_SHIFT
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int unsigned RECIP10_SHIFT = 35;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // One classified number waiting for digit generation
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } ddf_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ddf_qstat_t;

    // Power of ten, evaluated at elaboration only
    function automatic logic [63:0] pow10(input int unsigned n);
        logic [63:0] p;
        p = 64'd1;
        for (int unsigned i = 0; i < n; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

[rtl/ddf_front.sv]
// ----------------------------------------------------------------------------
// ddf_front
// Accept a number, saturate its digit count and flag overflow.
// ----------------------------------------------------------------------------
module ddf_front #(
    parameter int unsigned DIGITS = 8
) (
    input  logic                        start,
    input  logic [ddf_pkg::VALUE_W-1:0] value,
    input  logic [ddf_pkg::COUNT_W-1:0] digit_count,
    input  ddf_pkg::ddf_qstat_t         qstat,
    output logic                        busy,
    output logic                        push,
    output ddf_pkg::ddf_item_t          item
);

    localparam logic [ddf_pkg::VALUE_W-1:0] LIMIT =
        ddf_pkg::VALUE_W'(ddf_pkg::pow10(DIGITS));
    localparam logic [ddf_pkg::COUNT_W-1:0] MAX_COUNT = ddf_pkg::COUNT_W'(DIGITS);

    assign busy = qstat.full;
    assign push = start & ~qstat.full;

    always_comb
    begin
        item.value = value;
        item.count = (digit_count > MAX_COUNT) ? MAX_COUNT : digit_count;
        item.ovf   = (value >= LIMIT);
    end

endmodule

[rtl/ddf_queue.sv]
// ----------------------------------------------------------------------------
// ddf_queue
// Two-entry queue between the front and the digit generator.
// ----------------------------------------------------------------------------
`include "decimal_digit_display_framer_unit_defines.svh"

module ddf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ddf_pkg::ddf_item_t  push_item,
    input  logic                pop,
    output ddf_pkg::ddf_item_t  head,
    output ddf_pkg::ddf_qstat_t qstat
);

    ddf_pkg::ddf_item_t mem_reg [ddf_pkg::QUEUE_DEPTH];

    logic [ddf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ddf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ddf_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + ddf_pkg::QCNT_W'(push) - ddf_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (cnt_reg == ddf_pkg::QCNT_W'(ddf_pkg::QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);

    `DDF_ASSERT_NOW(a_q_no_overrun, push, !qstat.full, "queue written while full")
    `DDF_ASSERT_NOW(a_q_no_underrun, pop, !qstat.empty, "queue read while empty")

endmodule

[rtl/ddf_back.sv]
// ----------------------------------------------------------------------------
// ddf_back
// Emit one digit-register write per cycle, least significant digit first.
// ----------------------------------------------------------------------------
`include "decimal_digit_display_framer_unit_defines.svh"

module ddf_back #(
    parameter int unsigned DIGITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ddf_pkg::ddf_item_t          head,
    input  ddf_pkg::ddf_qstat_t         qstat,
    output logic                        pop,
    output logic                        strobe,
    output logic [ddf_pkg::ADDR_W-1:0]  digit_address,
    output logic [ddf_pkg::CODE_W-1:0]  digit_code,
    output logic                        overflow,
    output logic                        last
);

    localparam logic [ddf_pkg::ADDR_W-1:0] LAST_ADDR = ddf_pkg::ADDR_W'(DIGITS);

    // Working item
    logic                        active_reg, active_next;
    logic [ddf_pkg::VALUE_W-1:0] num_reg, num_next;
    logic [ddf_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [ddf_pkg::ADDR_W-1:0]  addr_reg, addr_next;

    // Output write
    logic                        strobe_reg, strobe_next;
    logic [ddf_pkg::ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [ddf_pkg::CODE_W-1:0]  out_code_reg, out_code_next;
    logic                        out_ovf_reg, out_ovf_next;
    logic                        out_last_reg, out_last_next;

    logic [63:0]                 prod;
    logic [ddf_pkg::VALUE_W-1:0] quot;
    logic [ddf_pkg::CODE_W-1:0]  rem;
    logic                        final_step;

    // Divide by ten through the reciprocal; remainder from the low bits
    always_comb
    begin
        prod = {1'b0, num_reg} * ddf_pkg::RECIP10;
        quot = ddf_pkg::VALUE_W'(prod[63:ddf_pkg::RECIP10_SHIFT]);
        rem  = ddf_pkg::CODE_W'(num_reg - ((quot << 3) + (quot << 1)));
    end

    assign final_step = active_reg && (addr_reg == LAST_ADDR);
    assign pop        = !qstat.empty && (!active_reg || final_step);

    always_comb
    begin
        active_next   = active_reg;
        num_next      = num_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        addr_next     = addr_reg;
        strobe_next   = active_reg;
        out_addr_next = addr_reg;
        out_code_next = (addr_reg <= count_reg) ? rem : ddf_pkg::BLANK_CODE;
        out_ovf_next  = ovf_reg;
        out_last_next = final_step;

        if (active_reg)
        begin
            num_next  = quot;
            addr_next = addr_reg + 1'b1;
        end

        if (pop)
        begin
            active_next = 1'b1;
            num_next    = head.value;
            count_next  = head.count;
            ovf_next    = head.ovf;
            addr_next   = ddf_pkg::ADDR_W'(1);
        end
        else if (final_step)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        count_reg    <= count_next;
        ovf_reg      <= ovf_next;
        addr_reg     <= addr_next;
        out_addr_reg <= out_addr_next;
        out_code_reg <= out_code_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign strobe        = strobe_reg;
    assign digit_address = out_addr_reg;
    assign digit_code    = out_code_reg;
    assign overflow      = out_ovf_reg;
    assign last          = out_last_reg;

    `DDF_ASSERT_NEXT(a_back_contiguous, strobe_reg && !out_last_reg, strobe_reg,
        "digit writes of one number are not contiguous")
    `DDF_ASSERT_NOW(a_back_code_range, strobe_reg && out_code_reg != ddf_pkg::BLANK_CODE,
        out_code_reg < 4'd10, "digit code out of decimal range")
    `DDF_ASSERT_NEXT(a_back_overflow_held, strobe_reg && !out_last_reg,
        out_ovf_reg == $past(out_ovf_reg), "overflow flag changed within a number")

endmodule

[rtl/decimal_digit_display_framer_unit.sv]
// ----------------------------------------------------------------------------
// Decimal digit display framer
// Turns a binary number into digit-register writes for a decoded
// seven-segment driver.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive value and digit_count and raise start; the beat is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only while the two-entry queue between front and digit generator is full.
//   Output channel: each beat is one digit write (digit_address 1..DIGITS,
//   digit_code 0-9 or 15 for blank, overflow, last) shown for exactly one
//   cycle with strobe high. The receiver cannot stall; every beat is taken.
//   Path: an accepted number waits in the queue, is loaded into the digit
//   generator and leaves through its registered output; its DIGITS writes
//   then follow on consecutive cycles, the last one flagged with last.
//   Throughput: the digit generator emits one write per cycle (one
//   divide-by-ten step each cycle) and takes no new number until its last
//   write. Numbers arriving back to back give an unbroken stream of writes.
//   Reset: rst_n clears the queue and the generator; no writes are pending.
// ----------------------------------------------------------------------------
module decimal_digit_display_framer_unit #(
    parameter int unsigned DIGITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ddf_pkg::VALUE_W-1:0] value,
    input  logic [ddf_pkg::COUNT_W-1:0] digit_count,
    output logic                        strobe,
    output logic [ddf_pkg::ADDR_W-1:0]  digit_address,
    output logic [ddf_pkg::CODE_W-1:0]  digit_code,
    output logic                        overflow,
    output logic                        last
);

    logic                push;
    logic                pop;
    ddf_pkg::ddf_item_t  push_item;
    ddf_pkg::ddf_item_t  head;
    ddf_pkg::ddf_qstat_t qstat;

    // Front: accept the beat, saturate the count, flag overflow
    ddf_front #(
        .DIGITS      (DIGITS)
    ) u_front (
        .start       (start),
        .value       (value),
        .digit_count (digit_count),
        .qstat       (qstat),
        .busy        (busy),
        .push        (push),
        .item        (push_item)
    );

    // Queue: hold classified numbers so front and back stall on their own
    ddf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Back: advance one digit per cycle, blank the positions above the count
    ddf_back #(
        .DIGITS        (DIGITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .qstat         (qstat),
        .pop           (pop),
        .strobe        (strobe),
        .digit_address (digit_address),
        .digit_code    (digit_code),
        .overflow      (overflow),
        .last          (last)
    );

endmodule

[sim/tb_decimal_digit_display_framer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit display framer testbench
// Sends numbers with digit counts through the command port and checks every
// digit write against a local model of the framer. The run has a directed
// part, a back-to-back burst and random numbers with random idle gaps.
// ----------------------------------------------------------------------------
module tb_decimal_digit_display_framer_unit;

    localparam int          DIGITS        = 8;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          TAIL_CYCLES   = 16;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          RANDOM_ITEMS  = 66;
    localparam int          BURST_ITEMS   = 12;

    // One digit-register write as the framer should emit it
    typedef struct {
        logic [ddf_pkg::ADDR_W-1:0] addr;
        logic [ddf_pkg::CODE_W-1:0] code;
        logic                       ovf;
        logic                       last;
    } digit_write_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [ddf_pkg::VALUE_W-1:0]  value;
    logic [ddf_pkg::COUNT_W-1:0]  digit_count;
    logic                         strobe;
    logic [ddf_pkg::ADDR_W-1:0]   digit_address;
    logic [ddf_pkg::CODE_W-1:0]   digit_code;
    logic                         overflow;
    logic                         last;

    // Writes still owed by the framer, oldest first
    digit_write_t pending_writes[$];

    int numbers_sent;
    int writes_checked;
    int mismatch_count;
    int overflow_numbers;
    int saturated_counts;
    int blank_numbers;
    int idle_cycles;

    decimal_digit_display_framer_unit #(
        .DIGITS        (DIGITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .digit_count   (digit_count),
        .strobe        (strobe),
        .digit_address (digit_address),
        .digit_code    (digit_code),
        .overflow      (overflow),
        .last          (last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Digit model: split the number into decimal digits, least significant
    // first, blank every position above the (saturated) count, and flag all
    // writes of a number that does not fit in DIGITS decimal places.
    // ------------------------------------------------------------------------
    task automatic predict_digit_writes(input logic [ddf_pkg::VALUE_W-1:0] num,
                                        input logic [ddf_pkg::COUNT_W-1:0] cnt);
        longint unsigned rest;
        longint unsigned span;
        int              shown;
        logic            too_big;
        digit_write_t    w;
        rest  = num;
        span  = 1;
        shown = (cnt > DIGITS) ? DIGITS : int'(cnt);
        for (int i = 0; i < DIGITS; i++)
        begin
            span = span * 10;
        end
        too_big = (rest >= span);
        for (int pos = 1; pos <= DIGITS; pos++)
        begin
            w.addr = pos[ddf_pkg::ADDR_W-1:0];
            // a blanked position hides the digit but still consumes it
            w.code = (pos <= shown) ? ddf_pkg::CODE_W'(rest % 10) : ddf_pkg::BLANK_CODE;
            rest   = rest / 10;
            w.ovf  = too_big;
            w.last = (pos == DIGITS);
            pending_writes.push_back(w);
        end
        if (too_big)
        begin
            overflow_numbers++;
        end
        if (cnt > DIGITS)
        begin
            saturated_counts++;
        end
        if (cnt == 0)
        begin
            blank_numbers++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Present one number and hold it until the framer takes the beat. Leave
    // start high afterwards so a following send can go out back to back.
    task automatic send_number(input logic [ddf_pkg::VALUE_W-1:0] num,
                               input logic [ddf_pkg::COUNT_W-1:0] cnt);
        @(negedge clk);
        start       <= 1'b1;
        value       <= num;
        digit_count <= cnt;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_digit_writes(num, cnt);
        numbers_sent++;
    endtask

    // Drop start for a random number of cycles: mostly none or short, a few
    // long. Scramble the data lines meanwhile; the framer must ignore them.
    task automatic idle_gap();
        int n;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            n = 0;
        end
        else if (pick < 9)
        begin
            n = $urandom_range(1, 3);
        end
        else
        begin
            n = $urandom_range(5, 40);
        end
        if (n > 0)
        begin
            @(negedge clk);
            start       <= 1'b0;
            value       <= ddf_pkg::VALUE_W'($urandom);
            digit_count <= ddf_pkg::COUNT_W'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stop sending and hold off until every owed write has come out
    task automatic wait_for_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [ddf_pkg::VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: return ddf_pkg::VALUE_W'($urandom_range(0, 99999999));
            4, 5:       return ddf_pkg::VALUE_W'($urandom);
            6:          return ddf_pkg::VALUE_W'($urandom_range(0, 999));
            7:          return ddf_pkg::VALUE_W'($urandom_range(99999990, 100000009));
            8:          return ddf_pkg::VALUE_W'(2147483647 - $urandom_range(0, 15));
            default:    return ddf_pkg::VALUE_W'($urandom_range(100000000, 2147483647));
        endcase
    endfunction

    function automatic logic [ddf_pkg::COUNT_W-1:0] random_count();
        if ($urandom_range(0, 9) < 7)
        begin
            return ddf_pkg::COUNT_W'($urandom_range(0, DIGITS));
        end
        return ddf_pkg::COUNT_W'($urandom_range(DIGITS + 1, 15));
    endfunction

    // ------------------------------------------------------------------------
    // Result side: the receiver cannot stall, so take every strobed beat and
    // compare it field by field with the oldest owed write.
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input digit_write_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch on %s: expected addr=%0d code=%0d ovf=%0b last=%0b,",
                     $realtime, what, want.addr, want.code, want.ovf, want.last);
            $display("          got addr=%0d code=%0d ovf=%0b last=%0b",
                     digit_address, digit_code, overflow, last);
        end
    endtask

    always @(posedge clk)
    begin
        digit_write_t want;
        if (rst_n && strobe)
        begin
            if (pending_writes.size() == 0)
            begin
                want = '{addr: '0, code: '0, ovf: 1'b0, last: 1'b0};
                note_mismatch("unexpected beat", want);
            end
            else
            begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (digit_address !== want.addr)
                begin
                    note_mismatch("digit_address", want);
                end
                if (digit_code !== want.code)
                begin
                    note_mismatch("digit_code", want);
                end
                if (overflow !== want.ovf)
                begin
                    note_mismatch("overflow", want);
                end
                if (last !== want.last)
                begin
                    note_mismatch("last", want);
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || strobe))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d writes still owed",
                     IDLE_LIMIT, pending_writes.size());
            $display("decimal_digit_display_framer_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and the special cases: all blank, all digits, overflow
    // just above the eight-digit range, saturated count, blanked nonzero
    // digits of a large number.
    task automatic test_extremes();
        send_number(31'd0,          4'd8);
        send_number(31'd2147483647, 4'd8);
        send_number(31'd2147483647, 4'd0);
        send_number(31'd99999999,   4'd8);
        send_number(31'd100000000,  4'd8);
        send_number(31'd100000000,  4'd0);
        send_number(31'd12345678,   4'd15);
        send_number(31'd98765432,   4'd3);
        send_number(31'd7,          4'd1);
        send_number(31'd90807060,   4'd9);
        wait_for_drain();
    endtask

    // Walk the count through every legal size and a few saturating ones
    task automatic test_digit_counts();
        for (int c = 0; c <= DIGITS; c++)
        begin
            send_number(31'd87654321, ddf_pkg::COUNT_W'(c));
        end
        send_number(31'd87654321, 4'd9);
        send_number(31'd87654321, 4'd12);
        send_number(31'd1234567890, 4'd15);
        wait_for_drain();
    endtask

    // Hold start high across numbers so the writes come out as one stream
    task automatic test_back_to_back();
        for (int i = 0; i < BURST_ITEMS; i++)
        begin
            send_number(random_value(), random_count());
        end
        wait_for_drain();
    endtask

    // Random numbers and gaps; pause for a full drain every so often so
    // the framer also restarts from empty in the middle of the run
    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_gap();
            send_number(random_value(), random_count());
            if ((i % 30) == 29)
            begin
                wait_for_drain();
            end
        end
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        value            = '0;
        digit_count      = '0;
        numbers_sent     = 0;
        writes_checked   = 0;
        mismatch_count   = 0;
        overflow_numbers = 0;
        saturated_counts = 0;
        blank_numbers    = 0;
        idle_cycles      = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_digit_counts();
        test_back_to_back();
        test_random();

        // catch any stray beat after the last owed write
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d numbers and %0d digit writes: %0d overflowing,",
                 numbers_sent, writes_checked, overflow_numbers);
        $display("  %0d with saturated count, %0d fully blank; %0d mismatches",
                 saturated_counts, blank_numbers, mismatch_count);
        if (mismatch_count == 0 && pending_writes.size() == 0)
        begin
            $display("decimal_digit_display_framer_unit test passed");
        end
        else
        begin
            $display("decimal_digit_display_framer_unit test failed");
        end
        $finish;
    end

endmodule
